// ===== rtl/lbg_pkg.sv =====
// ----------------------------------------------------------------------------
// lbg_pkg
// shared constants, types and stencil tables of the d2q9 bgk collision unit
// ----------------------------------------------------------------------------
package lbg_pkg;

   // field widths and fixed-point formats
   localparam int FIELD_WIDTH  = 32;
   localparam int DIR_BITS     = 4;
   localparam int FRAC_BITS    = 24;
   localparam int WEIGHT_BITS  = 30;
   localparam int RATE_BITS    = 30;
   localparam int RATE_WIDTH   = RATE_BITS + 2;
   localparam int PROD_WIDTH   = 2 * FIELD_WIDTH;
   localparam int CALC_WIDTH   = 72;
   localparam int DATA_WIDTH   = 32;

   // stencil
   localparam int STENCIL_SIZE       = 9;
   localparam int INV_SOUND_SPEED_SQ = 3;

   // stream and register port
   localparam int REQ_TDATA_WIDTH = ((DIR_BITS + 6 * FIELD_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((FIELD_WIDTH + 7) / 8) * 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam logic REG_SEL_FIRST  = 1'b0;
   localparam logic REG_SEL_SECOND = 1'b1;

   // pipeline
   localparam int NUM_STAGES = 9;

   // q0.30 weights
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_REST = 30'd477218588;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_AXIS = 30'd119304647;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_DIAG = 30'd29826162;

   localparam logic [RATE_WIDTH-1:0] RATE_MAX = RATE_WIDTH'(1) << (RATE_BITS + 1);

   typedef logic signed [FIELD_WIDTH-1:0] data_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [1:0]             dir_type;

   localparam data_type ONE_Q = FIELD_WIDTH'(1) << FRAC_BITS;

   typedef struct packed {
      logic     clipped;
      data_type value;
   } sat_type;

   function automatic dir_type dir_x(input logic [DIR_BITS-1:0] p);
      dir_type r;
      r = '0;
      if (p < STENCIL_SIZE) begin
         case (p) inside
            4'd1, 4'd5, 4'd8: r = 2'sb01;
            4'd3, 4'd6, 4'd7: r = 2'sb11;
            default:          r = 2'sb00;
         endcase
      end
      return r;
   endfunction

   function automatic dir_type dir_y(input logic [DIR_BITS-1:0] p);
      dir_type r;
      r = '0;
      if (p < STENCIL_SIZE) begin
         case (p) inside
            4'd2, 4'd5, 4'd6: r = 2'sb01;
            4'd4, 4'd7, 4'd8: r = 2'sb11;
            default:          r = 2'sb00;
         endcase
      end
      return r;
   endfunction

   function automatic logic [WEIGHT_BITS-1:0] dir_weight(input logic [DIR_BITS-1:0] p);
      logic [WEIGHT_BITS-1:0] r;
      r = '0;
      if (p < STENCIL_SIZE) begin
         case (p) inside
            4'd0:                   r = WEIGHT_REST;
            4'd1, 4'd2, 4'd3, 4'd4: r = WEIGHT_AXIS;
            default:                r = WEIGHT_DIAG;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== rtl/lbm_bgk_guo_collision_unit.sv =====
// ----------------------------------------------------------------------------
// lbm_bgk_guo_collision_unit
// d2q9 bgk collision with guo forcing, signed q8.24, saturating pipeline
// ----------------------------------------------------------------------------
// usage
//   req_* carries one population of one cell per transaction: direction,
//   old value, density, velocity, force and (in tuser) the fluid component.
//   rsp_* returns the post-collision value and (in tuser) a flag that is set
//   when any intermediate or the result hit the saturation limits.
//   csr_* holds the two relaxation rates (omega, unsigned q2.30) at byte
//   addresses 0 and 4; rates above 2.0 are used as 2.0. write only while
//   no transaction is in flight.
// timing
//   nine register stages plus the output register: a transaction accepted
//   at one edge passes through stages 1 to 9 and the output register before
//   it is presented on rsp_*. one transaction per cycle is sustained while
//   rsp_tready is high; the depth is set by the chain of dependent 32x32
//   multiplies (velocity squares, force products, density, weight, omega).
// reset and stall
//   reset empties the pipeline and sets both rates to 1.0. when rsp_tready
//   is low the result holds and each stage stalls only when the one after it
//   is full, so bubbles are squeezed out and input is still taken until
//   every stage holds a transaction.
// ----------------------------------------------------------------------------
module lbm_bgk_guo_collision_unit
   import lbg_pkg::*;
#(
   parameter int DATA_WIDTH = lbg_pkg::DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // population_index, old_population, density, velocity_x, velocity_y,
   // force_x, force_y, zero pad
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // component
   input  logic                       req_tuser,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // new_population
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // saturated
   output logic                       rsp_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                       csr_pready
);

   localparam int EFF_WIDTH = (DATA_WIDTH < FIELD_WIDTH) ? DATA_WIDTH : FIELD_WIDTH;
   localparam int DW1       = FIELD_WIDTH + 1;
   localparam logic signed [CALC_WIDTH-1:0] SAT_HI =
      {{(CALC_WIDTH - EFF_WIDTH + 1){1'b0}}, {(EFF_WIDTH - 1){1'b1}}};
   localparam logic signed [CALC_WIDTH-1:0] SAT_LO =
      {{(CALC_WIDTH - EFF_WIDTH + 1){1'b1}}, {(EFF_WIDTH - 1){1'b0}}};
   localparam logic signed [CALC_WIDTH-1:0] K  = CALC_WIDTH'(INV_SOUND_SPEED_SQ);
   localparam logic signed [CALC_WIDTH-1:0] K2 = CALC_WIDTH'(INV_SOUND_SPEED_SQ *
                                                            INV_SOUND_SPEED_SQ);

   typedef logic signed [CALC_WIDTH-1:0] calc_type;
   typedef logic [RATE_WIDTH-1:0]        rate_type;
   typedef logic [WEIGHT_BITS-1:0]       weight_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      data_type   rho;
      data_type   u;
      data_type   v;
      data_type   fx;
      data_type   fy;
      data_type   uc;
      dir_type    cx;
      dir_type    cy;
      weight_type w;
      rate_type   omega;
   } s1_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      data_type   rho;
      data_type   fx;
      data_type   fy;
      data_type   uc;
      data_type   sx;
      data_type   sy;
      prod_type   ucuc;
      prod_type   uu;
      prod_type   vv;
      weight_type w;
      rate_type   omega;
   } s2_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      data_type   rho;
      data_type   uc;
      data_type   uc2;
      data_type   u2;
      prod_type   sxfx;
      prod_type   syfy;
      weight_type w;
      rate_type   omega;
   } s3_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      data_type   rho;
      data_type   bracket;
      data_type   fsum;
      weight_type w;
      rate_type   omega;
   } s4_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      prod_type   rb;
      prod_type   wf;
      weight_type w;
      rate_type   omega;
   } s5_type;

   typedef struct packed {
      logic       clipped;
      data_type   f;
      data_type   rbq;
      data_type   force_q;
      weight_type w;
      rate_type   omega;
   } s6_type;

   typedef struct packed {
      logic     clipped;
      data_type f;
      data_type force_q;
      prod_type wrb;
      prod_type ofp;
      rate_type omega;
   } s7_type;

   typedef struct packed {
      logic                   clipped;
      data_type               f;
      data_type               force_q;
      logic signed [DW1-1:0]  diff;
      logic signed [DW1-1:0]  ft;
      rate_type               omega;
   } s8_type;

   typedef struct packed {
      logic                        clipped;
      data_type                    f;
      data_type                    force_q;
      logic signed [DW1-1:0]       ft;
      logic signed [PROD_WIDTH:0]  od;
   } s9_type;

   function automatic sat_type sat(input calc_type x);
      sat_type r;
      if (x > SAT_HI) begin
         r.clipped = 1'b1;
         r.value   = SAT_HI[FIELD_WIDTH-1:0];
      end else if (x < SAT_LO) begin
         r.clipped = 1'b1;
         r.value   = SAT_LO[FIELD_WIDTH-1:0];
      end else begin
         r.clipped = 1'b0;
         r.value   = x[FIELD_WIDTH-1:0];
      end
      return r;
   endfunction

   // round half up, then floor shift
   function automatic calc_type rnd(input calc_type x, input int unsigned s);
      calc_type half;
      half = $signed(CALC_WIDTH'(1) << (s - 1));
      return (x + half) >>> s;
   endfunction

   // a times a lattice unit of -1, 0 or +1
   function automatic calc_type pick(input data_type a, input dir_type c);
      calc_type r;
      case (c)
         2'sb01:  r = CALC_WIDTH'(a);
         2'sb11:  r = -CALC_WIDTH'(a);
         default: r = '0;
      endcase
      return r;
   endfunction

   // configuration registers
   logic [CSR_DATA_WIDTH-1:0] relax_first_ff, relax_first_in;
   logic [CSR_DATA_WIDTH-1:0] relax_second_ff, relax_second_in;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      relax_first_in  = relax_first_ff;
      relax_second_in = relax_second_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SEL_FIRST:  relax_first_in  = csr_pwdata;
            REG_SEL_SECOND: relax_second_in = csr_pwdata;
            default:        relax_first_in  = relax_first_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SEL_FIRST:  csr_prdata = relax_first_ff;
         REG_SEL_SECOND: csr_prdata = relax_second_ff;
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_first_ff  <= CSR_DATA_WIDTH'(1) << RATE_BITS;
         relax_second_ff <= CSR_DATA_WIDTH'(1) << RATE_BITS;
      end else begin
         relax_first_ff  <= relax_first_in;
         relax_second_ff <= relax_second_in;
      end
   end

   // pipeline flow control
   logic [NUM_STAGES:1]   valid_ff, valid_in;
   logic [NUM_STAGES+1:1] stage_enable;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      stage_enable[NUM_STAGES+1] = !rsp_valid_ff || rsp_tready;
      for (int i = NUM_STAGES; i >= 1; i--) begin
         stage_enable[i] = !valid_ff[i] || stage_enable[i+1];
      end
      valid_in[1] = stage_enable[1] ? req_tvalid : valid_ff[1];
      for (int i = 2; i <= NUM_STAGES; i++) begin
         valid_in[i] = stage_enable[i] ? valid_ff[i-1] : valid_ff[i];
      end
      rsp_valid_in = stage_enable[NUM_STAGES+1] ? valid_ff[NUM_STAGES] : rsp_valid_ff;
   end

   assign req_tready = stage_enable[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: input saturation, stencil lookup, rate select, u.c
   s1_type s1_ff, s1_in;

   always_comb begin
      logic [DIR_BITS-1:0]       p;
      logic [CSR_DATA_WIDTH-1:0] rate;
      sat_type                   f_s, rho_s, u_s, v_s, fx_s, fy_s, uc_s;
      p     = req_tdata[DIR_BITS-1:0];
      f_s   = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS +: FIELD_WIDTH])));
      rho_s = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS + FIELD_WIDTH +: FIELD_WIDTH])));
      u_s   = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS + 2*FIELD_WIDTH +: FIELD_WIDTH])));
      v_s   = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS + 3*FIELD_WIDTH +: FIELD_WIDTH])));
      fx_s  = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS + 4*FIELD_WIDTH +: FIELD_WIDTH])));
      fy_s  = sat(CALC_WIDTH'($signed(req_tdata[DIR_BITS + 5*FIELD_WIDTH +: FIELD_WIDTH])));
      s1_in.cx = dir_x(p);
      s1_in.cy = dir_y(p);
      s1_in.w  = dir_weight(p);
      uc_s = sat(pick(u_s.value, s1_in.cx) + pick(v_s.value, s1_in.cy));
      rate = req_tuser ? relax_second_ff : relax_first_ff;
      s1_in.omega = (RATE_WIDTH'(rate) > RATE_MAX) ? RATE_MAX : RATE_WIDTH'(rate);
      s1_in.f   = f_s.value;
      s1_in.rho = rho_s.value;
      s1_in.u   = u_s.value;
      s1_in.v   = v_s.value;
      s1_in.fx  = fx_s.value;
      s1_in.fy  = fy_s.value;
      s1_in.uc  = uc_s.value;
      s1_in.clipped = f_s.clipped | rho_s.clipped | u_s.clipped | v_s.clipped |
                      fx_s.clipped | fy_s.clipped | uc_s.clipped;
   end

   // stage 2: squares, forcing coefficients
   s2_type s2_ff, s2_in;

   always_comb begin
      sat_type sx_s, sy_s;
      sx_s = sat(K * (pick(ONE_Q, s1_ff.cx) - CALC_WIDTH'(s1_ff.u)) +
                 K2 * pick(s1_ff.uc, s1_ff.cx));
      sy_s = sat(K * (pick(ONE_Q, s1_ff.cy) - CALC_WIDTH'(s1_ff.v)) +
                 K2 * pick(s1_ff.uc, s1_ff.cy));
      s2_in.ucuc    = s1_ff.uc * s1_ff.uc;
      s2_in.uu      = s1_ff.u * s1_ff.u;
      s2_in.vv      = s1_ff.v * s1_ff.v;
      s2_in.sx      = sx_s.value;
      s2_in.sy      = sy_s.value;
      s2_in.f       = s1_ff.f;
      s2_in.rho     = s1_ff.rho;
      s2_in.fx      = s1_ff.fx;
      s2_in.fy      = s1_ff.fy;
      s2_in.uc      = s1_ff.uc;
      s2_in.w       = s1_ff.w;
      s2_in.omega   = s1_ff.omega;
      s2_in.clipped = s1_ff.clipped | sx_s.clipped | sy_s.clipped;
   end

   // stage 3: rounded squares, |u|^2, force products
   s3_type s3_ff, s3_in;

   always_comb begin
      sat_type uc2_s, uu_s, vv_s, u2_s;
      uc2_s = sat(rnd(CALC_WIDTH'(s2_ff.ucuc), FRAC_BITS));
      uu_s  = sat(rnd(CALC_WIDTH'(s2_ff.uu), FRAC_BITS));
      vv_s  = sat(rnd(CALC_WIDTH'(s2_ff.vv), FRAC_BITS));
      u2_s  = sat(CALC_WIDTH'(uu_s.value) + CALC_WIDTH'(vv_s.value));
      s3_in.sxfx    = s2_ff.sx * s2_ff.fx;
      s3_in.syfy    = s2_ff.sy * s2_ff.fy;
      s3_in.uc2     = uc2_s.value;
      s3_in.u2      = u2_s.value;
      s3_in.f       = s2_ff.f;
      s3_in.rho     = s2_ff.rho;
      s3_in.uc      = s2_ff.uc;
      s3_in.w       = s2_ff.w;
      s3_in.omega   = s2_ff.omega;
      s3_in.clipped = s2_ff.clipped | uc2_s.clipped | uu_s.clipped |
                      vv_s.clipped | u2_s.clipped;
   end

   // stage 4: equilibrium bracket and forcing sum
   s4_type s4_ff, s4_in;

   always_comb begin
      sat_type br_s, sxf_s, syf_s, fsum_s;
      // bracket is built at twice its value, then halved
      br_s   = sat(rnd((CALC_WIDTH'(ONE_Q) <<< 1) + (K <<< 1) * CALC_WIDTH'(s3_ff.uc) +
                       K2 * CALC_WIDTH'(s3_ff.uc2) - K * CALC_WIDTH'(s3_ff.u2), 1));
      sxf_s  = sat(rnd(CALC_WIDTH'(s3_ff.sxfx), FRAC_BITS));
      syf_s  = sat(rnd(CALC_WIDTH'(s3_ff.syfy), FRAC_BITS));
      fsum_s = sat(CALC_WIDTH'(sxf_s.value) + CALC_WIDTH'(syf_s.value));
      s4_in.bracket = br_s.value;
      s4_in.fsum    = fsum_s.value;
      s4_in.f       = s3_ff.f;
      s4_in.rho     = s3_ff.rho;
      s4_in.w       = s3_ff.w;
      s4_in.omega   = s3_ff.omega;
      s4_in.clipped = s3_ff.clipped | br_s.clipped | sxf_s.clipped |
                      syf_s.clipped | fsum_s.clipped;
   end

   // stage 5: density times bracket, weight times forcing sum
   s5_type s5_ff, s5_in;

   always_comb begin
      s5_in.rb      = s4_ff.rho * s4_ff.bracket;
      s5_in.wf      = $signed({1'b0, s4_ff.w}) * s4_ff.fsum;
      s5_in.f       = s4_ff.f;
      s5_in.w       = s4_ff.w;
      s5_in.omega   = s4_ff.omega;
      s5_in.clipped = s4_ff.clipped;
   end

   // stage 6: round both products
   s6_type s6_ff, s6_in;

   always_comb begin
      sat_type rbq_s, force_s;
      rbq_s   = sat(rnd(CALC_WIDTH'(s5_ff.rb), FRAC_BITS));
      force_s = sat(rnd(CALC_WIDTH'(s5_ff.wf), WEIGHT_BITS));
      s6_in.rbq     = rbq_s.value;
      s6_in.force_q = force_s.value;
      s6_in.f       = s5_ff.f;
      s6_in.w       = s5_ff.w;
      s6_in.omega   = s5_ff.omega;
      s6_in.clipped = s5_ff.clipped | rbq_s.clipped | force_s.clipped;
   end

   // stage 7: weight times rho*bracket, omega times forcing
   s7_type s7_ff, s7_in;

   always_comb begin
      s7_in.wrb     = $signed({1'b0, s6_ff.w}) * s6_ff.rbq;
      s7_in.ofp     = $signed({1'b0, s6_ff.omega}) * s6_ff.force_q;
      s7_in.f       = s6_ff.f;
      s7_in.force_q = s6_ff.force_q;
      s7_in.omega   = s6_ff.omega;
      s7_in.clipped = s6_ff.clipped;
   end

   // stage 8: feq, feq - f, halved omega forcing term
   s8_type s8_ff, s8_in;

   always_comb begin
      sat_type  feq_s;
      calc_type ft_c;
      feq_s = sat(rnd(CALC_WIDTH'(s7_ff.wrb), WEIGHT_BITS));
      ft_c  = rnd(CALC_WIDTH'(s7_ff.ofp), RATE_BITS + 1);
      s8_in.diff    = DW1'(feq_s.value) - DW1'(s7_ff.f);
      s8_in.ft      = ft_c[DW1-1:0];
      s8_in.f       = s7_ff.f;
      s8_in.force_q = s7_ff.force_q;
      s8_in.omega   = s7_ff.omega;
      s8_in.clipped = s7_ff.clipped | feq_s.clipped;
   end

   // stage 9: omega times (feq - f)
   s9_type s9_ff, s9_in;

   always_comb begin
      s9_in.od      = $signed({1'b0, s8_ff.omega}) * s8_ff.diff;
      s9_in.f       = s8_ff.f;
      s9_in.force_q = s8_ff.force_q;
      s9_in.ft      = s8_ff.ft;
      s9_in.clipped = s8_ff.clipped;
   end

   // output register: exact final sum, one saturation
   sat_type rsp_ff, rsp_in;

   always_comb begin
      sat_type total_s;
      total_s = sat(CALC_WIDTH'(s9_ff.f) + rnd(CALC_WIDTH'(s9_ff.od), RATE_BITS) +
                    CALC_WIDTH'(s9_ff.force_q) - CALC_WIDTH'(s9_ff.ft));
      rsp_in.value   = total_s.value;
      rsp_in.clipped = s9_ff.clipped | total_s.clipped;
   end

   always_ff @(posedge clock) begin
      if (stage_enable[1]) begin
         s1_ff <= s1_in;
      end
      if (stage_enable[2]) begin
         s2_ff <= s2_in;
      end
      if (stage_enable[3]) begin
         s3_ff <= s3_in;
      end
      if (stage_enable[4]) begin
         s4_ff <= s4_in;
      end
      if (stage_enable[5]) begin
         s5_ff <= s5_in;
      end
      if (stage_enable[6]) begin
         s6_ff <= s6_in;
      end
      if (stage_enable[7]) begin
         s7_ff <= s7_in;
      end
      if (stage_enable[8]) begin
         s8_ff <= s8_in;
      end
      if (stage_enable[9]) begin
         s9_ff <= s9_in;
      end
      if (stage_enable[NUM_STAGES+1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata  = RSP_TDATA_WIDTH'(rsp_ff.value);
   assign rsp_tuser  = rsp_ff.clipped;
   assign rsp_tvalid = rsp_valid_ff;

   // assertions
   a_omega_clamped: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> s1_ff.omega <= RATE_MAX)
      else $error("relaxation rate above two reached the pipeline");

   a_zero_weight_rest: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && s1_ff.w == '0 |-> s1_ff.cx == '0 && s1_ff.cy == '0)
      else $error("direction without weight has non-zero lattice velocity");

   for (genvar i = 1; i <= NUM_STAGES; i++) begin : g_hold
      a_stage_hold: assert property (@(posedge clock) disable iff (reset)
         valid_ff[i] && !stage_enable[i+1] |=> valid_ff[i])
         else $error("stalled pipeline stage lost its transaction");
   end

endmodule
